// ----- rtl/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [31:0] PAD_BYTE = 32'h00000080;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        final_item;
   } md5_entry_type;

   function automatic logic [31:0] md5_sine(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] md5_shift(input logic [5:0] i);
      logic [4:0] s;
      unique case ({i[5:4], i[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/md5_front.sv -----
// ----------------------------------------------------------------------------
// md5_front
// Classifies an incoming beat: saturates the byte count and masks idle bytes.
// ----------------------------------------------------------------------------
module md5_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_data_word,
   input  logic [2:0]            req_valid_bytes,
   input  logic                  req_final_item,
   output logic                  push_valid,
   output md5_pkg::md5_entry_type push_entry,
   input  logic                  queue_full
);
   import md5_pkg::*;

   logic [2:0]  nbytes;
   logic [31:0] mask;

   always_comb begin
      nbytes = (req_valid_bytes > 3'd4 || !req_final_item) ? 3'd4 : req_valid_bytes;
      unique case (nbytes)
         3'd0:    mask = 32'h00000000;
         3'd1:    mask = 32'h000000ff;
         3'd2:    mask = 32'h0000ffff;
         3'd3:    mask = 32'h00ffffff;
         default: mask = 32'hffffffff;
      endcase
   end

   assign push_valid            = req_valid && !queue_full;
   assign req_stall             = queue_full;
   assign push_entry.data       = req_data_word & mask;
   assign push_entry.nbytes     = nbytes;
   assign push_entry.final_item = req_final_item;

endmodule

// ----- rtl/md5_queue.sv -----
// ----------------------------------------------------------------------------
// md5_queue
// Small FIFO that decouples the input side from the compression engine.
// ----------------------------------------------------------------------------
module md5_queue #(
   parameter int DEPTH = md5_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  md5_pkg::md5_entry_type push_entry,
   output logic                   queue_full,
   input  logic                   pop,
   output logic                   pop_valid,
   output md5_pkg::md5_entry_type pop_entry
);
   import md5_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   md5_entry_type mem_ff [DEPTH];
   logic [IW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign queue_full = (cnt_ff == CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = mem_ff[rd_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == IW'(DEPTH - 1)) ? '0 : wr_ff + IW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == IW'(DEPTH - 1)) ? '0 : rd_ff + IW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/md5_engine.sv -----
// ----------------------------------------------------------------------------
// md5_engine
// Block buffer, padding, one MD5 round per cycle and digest output.
// ----------------------------------------------------------------------------
module md5_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   input  md5_pkg::md5_entry_type pop_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_digest_word,
   output logic [1:0]             rsp_word_index,
   output logic                   rsp_last_word
);
   import md5_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] buf_ff [16];
   logic [3:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] sum [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        fin_ff, fin_in, blk_ff, blk_in, two_ff, two_in;
   logic [31:0] fword_ff, fword_in;
   logic [6:0]  used_ff, used_in, used_new;
   logic [1:0]  idx_ff, idx_in;
   logic        ovalid_ff, ovalid_in;
   logic        buf_we;

   logic [3:0]  g;
   logic [4:0]  j, len_lo, len_hi;
   logic [31:0] f, m, t, rot, b_new;
   logic [63:0] rot_wide;
   logic [63:0] len_fin;

   // message schedule index and boolean function
   always_comb begin
      unique case (rnd_ff[5:4])
         2'd0: begin
            g = rnd_ff[3:0];
            f = (b_ff & c_ff) | (~b_ff & d_ff);
         end
         2'd1: begin
            g = rnd_ff[3:0] * 4'd5 + 4'd1;
            f = (b_ff & d_ff) | (c_ff & ~d_ff);
         end
         2'd2: begin
            g = rnd_ff[3:0] * 4'd3 + 4'd5;
            f = b_ff ^ c_ff ^ d_ff;
         end
         default: begin
            g = rnd_ff[3:0] * 4'd7;
            f = c_ff ^ (b_ff | ~d_ff);
         end
      endcase
   end

   // padded block word
   always_comb begin
      j      = {blk_ff, g};
      len_lo = two_ff ? 5'd30 : 5'd14;
      len_hi = two_ff ? 5'd31 : 5'd15;
      if (!fin_ff) begin
         m = buf_ff[g];
      end else begin
         m = '0;
         if (!blk_ff && g < pos_ff) begin
            m = buf_ff[g];
         end
         if (j == {1'b0, pos_ff}) begin
            m = m | fword_ff;
         end
         if (j == used_ff[6:2]) begin
            m = m | (PAD_BYTE << {used_ff[1:0], 3'b000});
         end
         if (j == len_lo) begin
            m = len_ff[31:0];
         end
         if (j == len_hi) begin
            m = len_ff[63:32];
         end
      end
   end

   always_comb begin
      t        = a_ff + f + md5_sine(rnd_ff) + m;
      rot_wide = {t, t} << md5_shift(rnd_ff);
      rot      = rot_wide[63:32];
      b_new    = b_ff + rot;
      sum[0]   = chain_ff[0] + a_ff;
      sum[1]   = chain_ff[1] + b_ff;
      sum[2]   = chain_ff[2] + c_ff;
      sum[3]   = chain_ff[3] + d_ff;
      len_fin  = len_ff + {58'd0, pop_entry.nbytes, 3'b000};
      used_new = {1'b0, pos_ff, 2'b00} + {4'd0, pop_entry.nbytes};
   end

   assign pop = pop_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      chain_in  = chain_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      rnd_in    = rnd_ff;
      fin_in    = fin_ff;
      blk_in    = blk_ff;
      two_in    = two_ff;
      fword_in  = fword_ff;
      used_in   = used_ff;
      idx_in    = idx_ff;
      ovalid_in = ovalid_ff;
      buf_we    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               a_in   = chain_ff[0];
               b_in   = chain_ff[1];
               c_in   = chain_ff[2];
               d_in   = chain_ff[3];
               rnd_in = '0;
               blk_in = 1'b0;
               if (!pop_entry.final_item) begin
                  buf_we = 1'b1;
                  fin_in = 1'b0;
                  len_in = len_ff + 64'd32;
                  if (pos_ff == 4'd15) begin
                     state_in = ST_RUN;
                  end else begin
                     pos_in = pos_ff + 4'd1;
                  end
               end else begin
                  fin_in   = 1'b1;
                  len_in   = len_fin;
                  fword_in = pop_entry.data;
                  used_in  = used_new;
                  two_in   = (used_new > 7'd55);
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            a_in   = d_ff;
            b_in   = b_new;
            c_in   = b_ff;
            d_in   = c_ff;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in = sum;
            if (!fin_ff) begin
               pos_in   = '0;
               state_in = ST_IDLE;
            end else if (!blk_ff && two_ff) begin
               blk_in   = 1'b1;
               a_in     = sum[0];
               b_in     = sum[1];
               c_in     = sum[2];
               d_in     = sum[3];
               rnd_in   = '0;
               state_in = ST_RUN;
            end else begin
               idx_in    = '0;
               ovalid_in = 1'b1;
               state_in  = ST_OUT;
            end
         end
         default: begin
            if (!rsp_stall) begin
               if (idx_ff == 2'd3) begin
                  ovalid_in   = 1'b0;
                  chain_in[0] = IV_A;
                  chain_in[1] = IV_B;
                  chain_in[2] = IV_C;
                  chain_in[3] = IV_D;
                  len_in      = '0;
                  pos_in      = '0;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pos_ff      <= '0;
         len_ff      <= '0;
         chain_ff[0] <= IV_A;
         chain_ff[1] <= IV_B;
         chain_ff[2] <= IV_C;
         chain_ff[3] <= IV_D;
         ovalid_ff   <= 1'b0;
         idx_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         chain_ff  <= chain_in;
         ovalid_ff <= ovalid_in;
         idx_ff    <= idx_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      rnd_ff   <= rnd_in;
      fin_ff   <= fin_in;
      blk_ff   <= blk_in;
      two_ff   <= two_in;
      fword_ff <= fword_in;
      used_ff  <= used_in;
      if (buf_we) begin
         buf_ff[pos_ff] <= pop_entry.data;
      end
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 2'd3);

endmodule

// ----- rtl/md5_message_digest.sv -----
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a little-endian word stream, four digest words per message.
// ----------------------------------------------------------------------------
// Message words enter a small queue and are drained by the compression engine,
// which runs one MD5 round per cycle. The engine takes a non-final word only
// while idle, and every sixteenth word starts a compression of 64 rounds plus
// the chaining add. A final word is followed by one padded block or two, then
// four digest beats follow, one per cycle while the receiver does not stall.
// The queue absorbs words while a compression is running.
module md5_message_digest #(
   parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_final_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import md5_pkg::*;

   logic          push_valid, queue_full, pop, pop_valid;
   md5_entry_type push_entry, pop_entry;

   md5_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_final_item  (req_final_item),
      .push_valid      (push_valid),
      .push_entry      (push_entry),
      .queue_full      (queue_full)
   );

   md5_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   md5_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_entry       (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

`ifndef SYNTHESIS
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_word |=>
         rsp_valid && rsp_word_index == $past(rsp_word_index) + 2'd1)
      else $error("digest word index did not advance");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_word |=> !rsp_valid)
      else $error("digest beats continue after last word");

   a_no_pop_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !pop)
      else $error("queue drained while digest pending");
`endif

endmodule
